/* sv/dmrg_pkg.sv */
// shared types, constants and helper functions for the multiple recursive generator
package dmrg_pkg;

   localparam int WORD_W       = 31;
   localparam int ORDER_W      = 13;
   localparam int GEN_TYPE_W   = 3;
   localparam int SEED_INDEX_W = 12;
   localparam int CSR_INDEX_W  = 1;
   localparam int READ_PORTS   = 4;

   // largest position that a 13-bit order can ever reach, plus one
   localparam int MAX_POSITIONS = (2 ** ORDER_W) - 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_TYPE = 1'b1;

   localparam logic [ORDER_W-1:0]    RESET_ORDER    = 13'd47;
   localparam logic [GEN_TYPE_W-1:0] RESET_GEN_TYPE = 3'd1;

   localparam logic [WORD_W-1:0] WORD_MASK = 31'd2147483647;
   localparam logic [29:0] MULT_S1 = 30'd536869888;
   localparam logic [29:0] MULT_S2 = 30'd65011712;
   localparam logic [29:0] MULT_S3 = 30'd67633152;
   localparam logic [29:0] MULT_S4 = 30'd67108736;

   // x / 3 == (x * 10923) >> 15 for every x below 2^15
   localparam logic [13:0] THIRD_RECIP = 14'd10923;
   localparam int          THIRD_SHIFT = 15;

   typedef enum logic [1:0] {
      GEN_S1,
      GEN_S2,
      GEN_S3,
      GEN_S4
   } gen_kind_type;

   typedef enum logic {
      MODE_GENERATE = 1'b0,
      MODE_LOAD     = 1'b1
   } mode_type;

   typedef struct packed {
      logic         step;
      logic         load;
      gen_kind_type kind;
   } pos_ctrl_type;

   typedef struct packed {
      logic [ORDER_W-1:0] run;
      logic [ORDER_W-1:0] half;
      logic [ORDER_W-1:0] two_thirds;
      logic [ORDER_W-1:0] third;
   } pos_init_type;

   function automatic gen_kind_type decode_kind(input logic [GEN_TYPE_W-1:0] t);
      gen_kind_type k;
      case (t)
         GEN_TYPE_W'(2): k = GEN_S2;
         GEN_TYPE_W'(3): k = GEN_S3;
         GEN_TYPE_W'(4): k = GEN_S4;
         default:        k = GEN_S1;
      endcase
      return k;
   endfunction

   function automatic logic [ORDER_W-1:0] advance(input logic [ORDER_W-1:0] p,
                                                  input logic [ORDER_W-1:0] k);
      logic [ORDER_W:0] n;
      n = {1'b0, p} + (ORDER_W+1)'(1);
      return (n >= {1'b0, k}) ? '0 : n[ORDER_W-1:0];
   endfunction

   // (q + k - 1) mod k for q below k
   function automatic logic [ORDER_W-1:0] tap_start(input logic [ORDER_W-1:0] q,
                                                    input logic [ORDER_W-1:0] k);
      return (q == '0) ? (k - ORDER_W'(1)) : (q - ORDER_W'(1));
   endfunction

   function automatic pos_init_type init_pos(input logic [ORDER_W-1:0] k);
      logic [27:0]        third_p;
      logic [27:0]        two_p;
      logic [ORDER_W-1:0] half_q;
      logic [ORDER_W-1:0] third_q;
      logic [ORDER_W-1:0] two_q;
      pos_init_type       res;
      half_q  = k >> 1;
      third_p = 28'(k) * 28'(THIRD_RECIP);
      two_p   = 28'({k, 1'b0}) * 28'(THIRD_RECIP);
      third_q = ORDER_W'(third_p >> THIRD_SHIFT);
      two_q   = ORDER_W'(two_p >> THIRD_SHIFT);
      res.run        = k - ORDER_W'(1);
      res.half       = tap_start(half_q, k);
      res.two_thirds = tap_start(two_q, k);
      res.third      = tap_start(third_q, k);
      return res;
   endfunction

endpackage

/* sv/dmrg_ring.sv */
// seed ring storage: two copies, each with one write and two registered reads
module dmrg_ring #(
   parameter int DEPTH = 4096
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [dmrg_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr [dmrg_pkg::READ_PORTS],
   output logic [dmrg_pkg::WORD_W-1:0] rd_data [dmrg_pkg::READ_PORTS]
);
   import dmrg_pkg::*;

   logic [WORD_W-1:0] ring_a_ff [DEPTH];
   logic [WORD_W-1:0] ring_b_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff [READ_PORTS];

   // copy a serves the running position and its predecessor
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_a_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff[0] <= ring_a_ff[rd_addr[0]];
         rd_data_ff[1] <= ring_a_ff[rd_addr[1]];
      end
   end

   // copy b serves the two extra taps
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_b_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff[2] <= ring_b_ff[rd_addr[2]];
         rd_data_ff[3] <= ring_b_ff[rd_addr[3]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dmrg_pos.sv */
// running position and tap registers with read address generation
module dmrg_pos #(
   parameter int DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dmrg_pkg::pos_ctrl_type          ctrl,
   input  logic [dmrg_pkg::ORDER_W-1:0]    order,
   output logic [$clog2(DEPTH)-1:0]        rd_addr [dmrg_pkg::READ_PORTS]
);
   import dmrg_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [ORDER_W-1:0] K_MAX   = ORDER_W'(DEPTH);
   localparam logic [ORDER_W-1:0] RESET_K = (K_MAX < RESET_ORDER) ? K_MAX : RESET_ORDER;

   logic [ORDER_W-1:0] eff_k;
   pos_init_type       init_now;
   pos_init_type       init_rst;

   logic [AW-1:0] run_ff, run_in, run_nxt;
   logic [AW-1:0] half_ff, half_in, half_nxt;
   logic [AW-1:0] tt_ff, tt_in, tt_nxt;
   logic [AW-1:0] th_ff, th_in, th_nxt;

   always_comb begin
      if (order == '0) begin
         eff_k = ORDER_W'(1);
      end else if (order > K_MAX) begin
         eff_k = K_MAX;
      end else begin
         eff_k = order;
      end
   end

   assign init_now = init_pos(eff_k);
   assign init_rst = init_pos(RESET_K);

   assign run_nxt  = AW'(advance(ORDER_W'(run_ff), eff_k));
   assign half_nxt = AW'(advance(ORDER_W'(half_ff), eff_k));
   assign tt_nxt   = AW'(advance(ORDER_W'(tt_ff), eff_k));
   assign th_nxt   = AW'(advance(ORDER_W'(th_ff), eff_k));

   // port 0 new position, port 1 previous position, ports 2 and 3 the taps
   assign rd_addr[0] = run_nxt;
   assign rd_addr[1] = run_ff;
   assign rd_addr[2] = (ctrl.kind == GEN_S3) ? half_nxt : tt_nxt;
   assign rd_addr[3] = th_nxt;

   always_comb begin
      run_in  = run_ff;
      half_in = half_ff;
      tt_in   = tt_ff;
      th_in   = th_ff;
      if (ctrl.load) begin
         run_in  = AW'(init_now.run);
         half_in = AW'(init_now.half);
         tt_in   = AW'(init_now.two_thirds);
         th_in   = AW'(init_now.third);
      end else if (ctrl.step) begin
         run_in = run_nxt;
         case (ctrl.kind)
            GEN_S3: begin
               half_in = half_nxt;
            end
            GEN_S4: begin
               tt_in = tt_nxt;
               th_in = th_nxt;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= AW'(init_rst.run);
         half_ff <= AW'(init_rst.half);
         tt_ff   <= AW'(init_rst.two_thirds);
         th_ff   <= AW'(init_rst.third);
      end else begin
         run_ff  <= run_in;
         half_ff <= half_in;
         tt_ff   <= tt_in;
         th_ff   <= th_in;
      end
   end

endmodule

/* sv/dmrg_calc.sv */
// bypass of the last ring write, term sum, multiply and modular fold
module dmrg_calc #(
   parameter int AW = 12
) (
   input  dmrg_pkg::gen_kind_type       kind,
   input  logic [AW-1:0]                rd_addr [dmrg_pkg::READ_PORTS],
   input  logic [dmrg_pkg::WORD_W-1:0]  rd_data [dmrg_pkg::READ_PORTS],
   input  logic                         fwd_valid,
   input  logic [AW-1:0]                fwd_addr,
   input  logic [dmrg_pkg::WORD_W-1:0]  fwd_data,
   output logic [dmrg_pkg::WORD_W-1:0]  result
);
   import dmrg_pkg::*;

   logic [WORD_W-1:0] w [READ_PORTS];
   logic [32:0]       sum_w;
   logic [29:0]       mult;
   logic [WORD_W-1:0] add_w;
   logic [62:0]       prod;
   logic [63:0]       v;
   logic [32:0]       folded;

   // the memory read missed a write landing on the same edge
   always_comb begin
      for (int i = 0; i < READ_PORTS; i++) begin
         w[i] = (fwd_valid && (fwd_addr == rd_addr[i])) ? fwd_data : rd_data[i];
      end
   end

   always_comb begin
      case (kind)
         GEN_S2: begin
            sum_w = 33'(w[0]) + 33'(w[1]);
            mult  = MULT_S2;
            add_w = '0;
         end
         GEN_S3: begin
            sum_w = 33'(w[0]) + 33'(w[2]) + 33'(w[1]);
            mult  = MULT_S3;
            add_w = '0;
         end
         GEN_S4: begin
            sum_w = 33'(w[0]) + 33'(w[2]) + 33'(w[3]) + 33'(w[1]);
            mult  = MULT_S4;
            add_w = '0;
         end
         default: begin
            sum_w = 33'(w[0]);
            mult  = MULT_S1;
            add_w = w[1];
         end
      endcase
   end

   assign prod   = 63'(sum_w) * 63'(mult);
   assign v      = 64'(prod) + 64'(add_w);
   assign folded = 33'(v[WORD_W-1:0]) + v[63:WORD_W];
   assign result = folded[WORD_W-1:0] & WORD_MASK;

endmodule

/* sv/dx_multiple_recursive_generator_core.sv */
// top level of the dx-k-s multiple recursive generator modulo 2^31-1
//
// request channel (req_*): req_mode 0 asks for the next number, req_mode 1
// loads req_seed_value into ring entry req_seed_index and re-initialises the
// running position and the taps from the current order. a load gives no
// response; an index at or beyond MAX_ORDER writes nothing.
// response channel (rsp_*): one rsp_random_value per generate request, in
// request order.
// csr port: csr_wen writes csr_wdata into register csr_index at the clock
// edge (0 order, 1 generator type); write only while the block is idle.
// a request accepted at an edge reads the ring at that edge; as the compute
// stage advances it writes the result back and into the response register,
// raising rsp_valid. throughput: one request per clock unless a stall holds
// the single compute stage (bypass, term sum, one multiply, fold) closing
// the loop between results; two ring copies give the four reads a cycle.
// reset: order 47, generator type 1, positions initialised for that order.
// ring contents stay undefined until loaded; there is no clearing pass.
// a stalled receiver holds the compute stage once the response register
// is full; req_ready then follows rsp_ready. loads still drain meanwhile.
module dx_multiple_recursive_generator_core #(
   parameter int MAX_ORDER = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [dmrg_pkg::SEED_INDEX_W-1:0]    req_seed_index,
   input  logic [dmrg_pkg::WORD_W-1:0]          req_seed_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dmrg_pkg::WORD_W-1:0]          rsp_random_value,
   input  logic                                 csr_wen,
   input  logic [dmrg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dmrg_pkg::ORDER_W-1:0]         csr_wdata
);
   import dmrg_pkg::*;

   // positions never exceed what a 13-bit order can reach
   localparam int RING_DEPTH = (MAX_ORDER < MAX_POSITIONS) ? MAX_ORDER : MAX_POSITIONS;
   localparam int AW         = $clog2(RING_DEPTH);

   // configuration registers
   logic [ORDER_W-1:0]    order_ff;
   logic [GEN_TYPE_W-1:0] gen_type_ff;

   // request side
   logic         accept;
   logic         req_is_load;
   logic         idx_ok;
   gen_kind_type kind;
   pos_ctrl_type pos_ctrl;
   logic [AW-1:0]     rd_addr [READ_PORTS];
   logic [WORD_W-1:0] rd_data [READ_PORTS];

   // compute stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_load_ff;
   logic              s1_wr_en_ff;
   gen_kind_type      s1_kind_ff;
   logic [AW-1:0]     s1_addr_ff [READ_PORTS];
   logic [AW-1:0]     s1_wr_addr_ff;
   logic [WORD_W-1:0] s1_seed_ff;
   logic              s1_adv;
   logic [WORD_W-1:0] calc_result;

   // ring write and bypass of the latest write
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic              last_wr_valid_ff;
   logic [AW-1:0]     last_wr_addr_ff;
   logic [WORD_W-1:0] last_wr_data_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= RESET_ORDER;
         gen_type_ff <= RESET_GEN_TYPE;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ORDER:    order_ff    <= csr_wdata;
            CSR_GEN_TYPE: gen_type_ff <= csr_wdata[GEN_TYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage moves on unless a generate result has nowhere to go
   assign s1_adv    = s1_valid_ff & (s1_load_ff | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign accept    = req_valid & req_ready;

   assign req_is_load = (req_mode == MODE_LOAD);
   assign idx_ok      = 32'(req_seed_index) < 32'(MAX_ORDER);
   assign kind        = decode_kind(gen_type_ff);

   assign pos_ctrl.step = accept & ~req_is_load;
   assign pos_ctrl.load = accept & req_is_load;
   assign pos_ctrl.kind = kind;

   dmrg_pos #(
      .DEPTH (RING_DEPTH)
   ) u_pos (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (pos_ctrl),
      .order   (order_ff),
      .rd_addr (rd_addr)
   );

   dmrg_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_wr_addr_ff),
      .wr_data (wr_data),
      .rd_en   (pos_ctrl.step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dmrg_calc #(
      .AW (AW)
   ) u_calc (
      .kind      (s1_kind_ff),
      .rd_addr   (s1_addr_ff),
      .rd_data   (rd_data),
      .fwd_valid (last_wr_valid_ff),
      .fwd_addr  (last_wr_addr_ff),
      .fwd_data  (last_wr_data_ff),
      .result    (calc_result)
   );

   // stage occupancy
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage payload, captured with the ring read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_load_ff    <= req_is_load;
         s1_wr_en_ff   <= req_is_load ? idx_ok : 1'b1;
         s1_kind_ff    <= kind;
         s1_addr_ff    <= rd_addr;
         s1_wr_addr_ff <= req_is_load ? AW'(req_seed_index) : rd_addr[0];
         s1_seed_ff    <= req_seed_value;
      end
   end

   // write back the new word or the loaded seed
   assign wr_en   = s1_adv & s1_wr_en_ff;
   assign wr_data = s1_load_ff ? s1_seed_ff : calc_result;

   // the latest write is the only one a pending read can miss
   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else if (wr_en) begin
         last_wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_addr_ff <= s1_wr_addr_ff;
         last_wr_data_ff <= wr_data;
      end
   end

   // response register
   always_comb begin
      if (s1_adv & ~s1_load_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv & ~s1_load_ff) begin
         rsp_value_ff <= calc_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule
